>>> rtl/pcd_pkg.sv
// Package: shared types, constants and status codes of the polyline character decoder.
package pcd_pkg;

	// Sum width default and allowed range
	localparam int SUM_WIDTH_DEFAULT = 32;
	localparam int SUM_WIDTH_MIN     = 24;
	localparam int SUM_WIDTH_MAX     = 64;

	// Character coding
	localparam logic [7:0] CHAR_BIAS  = 8'd63;
	localparam logic [7:0] CHAR_LAST  = 8'd126;
	localparam int         CHUNK_BITS = 5;
	localparam logic [2:0] MAX_CHUNKS = 3'd7;

	// Depth of the queue between front and back (power of two)
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		STATUS_POINT     = 2'd0,
		STATUS_BAD_CHAR  = 2'd1,
		STATUS_TOO_LONG  = 2'd2,
		STATUS_TRUNCATED = 2'd3
	} status_t;

	// Input item
	typedef struct packed {
		logic [7:0] char_code;
		logic       first_of_string;
		logic       end_of_string;
	} char_t;

	// Result item
	typedef struct packed {
		logic signed [31:0] lat_e5;
		logic signed [31:0] lng_e5;
		status_t            status;
	} point_t;

	// Classified character, as held in the queue
	typedef struct packed {
		logic                  bad;
		logic                  more;
		logic [CHUNK_BITS-1:0] chunk;
		logic                  first_of_string;
		logic                  end_of_string;
	} entry_t;

endpackage

>>> rtl/pcd_stream_if.sv
// Interface: valid/ready stream channel with a typed payload.
interface pcd_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/pcd_front.sv
// Front end: accepts characters and classifies them into queue entries.
module pcd_front (
	pcd_stream_if.sink      chars,
	input  logic            q_ready,
	output logic            push,
	output pcd_pkg::entry_t push_data
);

	logic [7:0] biased;

	// Take a character whenever the queue has room
	assign chars.ready = q_ready;
	assign push        = chars.valid && q_ready;

	// Classify: range check, strip bias, split chunk and continuation bit
	always_comb begin
		biased                    = chars.data.char_code - pcd_pkg::CHAR_BIAS;
		push_data.bad             = !(chars.data.char_code inside
			{[pcd_pkg::CHAR_BIAS:pcd_pkg::CHAR_LAST]});
		push_data.more            = biased[pcd_pkg::CHUNK_BITS];
		push_data.chunk           = biased[pcd_pkg::CHUNK_BITS-1:0];
		push_data.first_of_string = chars.data.first_of_string;
		push_data.end_of_string   = chars.data.end_of_string;
	end

endmodule

>>> rtl/pcd_queue.sv
// Short queue of classified characters between front and back.
module pcd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pcd_pkg::entry_t push_data,
	output logic            ready,
	input  logic            pop,
	output logic            valid,
	output pcd_pkg::entry_t pop_data
);

	localparam int Depth = pcd_pkg::QUEUE_DEPTH;
	localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW  = $clog2(Depth + 1);

	pcd_pkg::entry_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign ready    = (count_q != CntW'(Depth));
	assign valid    = (count_q != '0);
	assign pop_data = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth))
		else $error("queue count beyond depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid)
		else $error("pop from empty queue");

endmodule

>>> rtl/pcd_back.sv
// Back end: gathers chunks, zigzag-decodes values, keeps the sums, registers results.
module pcd_back #(
	parameter int SUM_WIDTH = pcd_pkg::SUM_WIDTH_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  pcd_pkg::entry_t q_data,
	output logic            pop,
	pcd_stream_if.source    points
);

	logic [31:0]                 acc_q;
	logic [2:0]                  cc_q;
	logic                        on_lng_q;
	logic signed [SUM_WIDTH-1:0] lat_sum_q;
	logic signed [SUM_WIDTH-1:0] lng_sum_q;
	logic                        out_valid_q;
	pcd_pkg::point_t             out_data_q;

	logic [31:0]                 acc_b;
	logic [2:0]                  cc_b;
	logic                        on_lng_b;
	logic signed [SUM_WIDTH-1:0] lat_b;
	logic signed [SUM_WIDTH-1:0] lng_b;
	logic [5:0]                  shamt;
	logic [31:0]                 acc_or;
	logic signed [31:0]          delta;
	logic [2:0]                  cc_inc;
	logic [31:0]                 acc_n;
	logic [2:0]                  cc_n;
	logic                        on_lng_n;
	logic signed [SUM_WIDTH-1:0] lat_n;
	logic signed [SUM_WIDTH-1:0] lng_n;
	logic                        has_res;
	pcd_pkg::status_t            res_status;

	// Take the next entry when the output register is free or being drained
	assign pop           = q_valid && (!out_valid_q || points.ready);
	assign points.valid  = out_valid_q;
	assign points.data   = out_data_q;

	// Execute one classified character
	always_comb begin
		acc_b    = q_data.first_of_string ? '0 : acc_q;
		cc_b     = q_data.first_of_string ? '0 : cc_q;
		on_lng_b = q_data.first_of_string ? 1'b0 : on_lng_q;
		lat_b    = q_data.first_of_string ? '0 : lat_sum_q;
		lng_b    = q_data.first_of_string ? '0 : lng_sum_q;

		// chunk lands at 5 * count; bits above 31 drop out
		shamt  = 6'({cc_b, 2'b00}) + 6'(cc_b);
		acc_or = acc_b | ({27'b0, q_data.chunk} << shamt);
		delta  = (acc_or >> 1) ^ {32{acc_or[0]}};
		cc_inc = cc_b + 3'd1;

		acc_n      = acc_b;
		cc_n       = cc_b;
		on_lng_n   = on_lng_b;
		lat_n      = lat_b;
		lng_n      = lng_b;
		has_res    = 1'b0;
		res_status = pcd_pkg::STATUS_POINT;

		if (q_data.bad) begin
			has_res    = 1'b1;
			res_status = pcd_pkg::STATUS_BAD_CHAR;
		end else if (q_data.more) begin
			if (cc_inc == pcd_pkg::MAX_CHUNKS) begin
				acc_n      = '0;
				cc_n       = '0;
				has_res    = 1'b1;
				res_status = pcd_pkg::STATUS_TOO_LONG;
			end else begin
				acc_n = acc_or;
				cc_n  = cc_inc;
			end
		end else begin
			acc_n = '0;
			cc_n  = '0;
			if (on_lng_b) begin
				lng_n      = lng_b + SUM_WIDTH'(delta);
				on_lng_n   = 1'b0;
				has_res    = 1'b1;
				res_status = pcd_pkg::STATUS_POINT;
			end else begin
				lat_n    = lat_b + SUM_WIDTH'(delta);
				on_lng_n = 1'b1;
			end
		end

		// End of string: flag an unfinished point, drop partial state
		if (q_data.end_of_string) begin
			if (!has_res && (cc_n != '0 || on_lng_n)) begin
				has_res    = 1'b1;
				res_status = pcd_pkg::STATUS_TRUNCATED;
			end
			acc_n    = '0;
			cc_n     = '0;
			on_lng_n = 1'b0;
		end
	end

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			cc_q      <= '0;
			on_lng_q  <= 1'b0;
			lat_sum_q <= '0;
			lng_sum_q <= '0;
		end else if (pop) begin
			acc_q     <= acc_n;
			cc_q      <= cc_n;
			on_lng_q  <= on_lng_n;
			lat_sum_q <= lat_n;
			lng_sum_q <= lng_n;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= has_res;
		end else if (points.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (pop && has_res) begin
			out_data_q.lat_e5 <= 32'(lat_n);
			out_data_q.lng_e5 <= 32'(lng_n);
			out_data_q.status <= res_status;
		end
	end

	a_cc_range: assert property (@(posedge clk) disable iff (!arst_n)
		cc_q != pcd_pkg::MAX_CHUNKS)
		else $error("chunk count reached limit");

	a_point_flips: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && has_res && res_status == pcd_pkg::STATUS_POINT) |=> !on_lng_q)
		else $error("point done but still on longitude");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && q_data.end_of_string) |=> (acc_q == '0 && cc_q == '0 && !on_lng_q))
		else $error("partial state kept past end of string");

endmodule

>>> rtl/polyline_char_decoder_top.sv
// Top level: encoded polyline decoder, one character per transfer.
//
// Usage:
//   chars  : one byte of an encoded polyline string per transfer, with
//            first_of_string (clears sums and partial value first) and
//            end_of_string (last byte; partial value is dropped after it).
//   points : one result per completed longitude value or per flagged error.
//            lat_e5 / lng_e5 are the running sums in 1e-5 degree, status is
//            point, bad character, value too long or truncated at end.
//   Path: a character's entry is held in a queue slot, then its result is
//   registered in the output register.
//   Throughput: one character per cycle while points.ready stays high, set
//   by the combinational accumulate/zigzag/add step in the back end.
//   Reset clears the queue, the output register, sums and partial value.
//   When points.ready is low the output register holds its result; the
//   two-entry queue keeps taking characters until it fills, then
//   chars.ready drops.
module polyline_char_decoder_top #(
	parameter int SUM_WIDTH = pcd_pkg::SUM_WIDTH_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	pcd_stream_if.sink   chars,
	pcd_stream_if.source points
);

	logic            q_push;
	logic            q_ready;
	logic            q_pop;
	logic            q_valid;
	pcd_pkg::entry_t q_push_data;
	pcd_pkg::entry_t q_pop_data;

	pcd_front u_front (
		.chars     (chars),
		.q_ready   (q_ready),
		.push      (q_push),
		.push_data (q_push_data)
	);

	pcd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.ready     (q_ready),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (q_pop_data)
	);

	pcd_back #(
		.SUM_WIDTH (SUM_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_pop_data),
		.pop     (q_pop),
		.points  (points)
	);

endmodule
